### hw/rtl/qbdi_pkg.sv
// ----------------------------------------------------------------------------
// qbdi_pkg
// Shared types, constants and saturation helpers of the QRS pre-processing
// datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qbdi_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int RING_AW    = $clog2(MAX_WINDOW);
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam int COEF_W = 18;
   localparam int BP_W   = 24;
   localparam int SQ_W   = 40;
   localparam int SUM_W  = 48;
   localparam int DLY_W  = 48;
   localparam int ACC_W  = 50;

   // Configuration register indexes.
   localparam logic [2:0] REG_B0   = 3'd0;
   localparam logic [2:0] REG_B1   = 3'd1;
   localparam logic [2:0] REG_B2   = 3'd2;
   localparam logic [2:0] REG_FB1  = 3'd3;
   localparam logic [2:0] REG_FB2  = 3'd4;
   localparam logic [2:0] REG_WLEN = 3'd5;
   localparam logic [2:0] REG_GAIN = 3'd6;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] fb1;
      logic signed [COEF_W-1:0] fb2;
   } qbdi_coef_type;

   // One emitted result on its way to the integrator.
   typedef struct packed {
      logic                   clr;
      logic signed [BP_W-1:0] bp;
      logic [SQ_W-1:0]        sq;
      logic                   eor;
      logic                   shrt;
   } qbdi_cmd_type;

   function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (DLY_W - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (v > hi) return hi[DLY_W-1:0];
      else if (v < lo) return lo[DLY_W-1:0];
      else return v[DLY_W-1:0];
   endfunction

   function automatic logic signed [BP_W-1:0] sat_bp(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (BP_W - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (v > hi) return hi[BP_W-1:0];
      else if (v < lo) return lo[BP_W-1:0];
      else return v[BP_W-1:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/qbdi_fifo.sv
// ----------------------------------------------------------------------------
// qbdi_fifo
// Short queue of result commands between the filter front and the integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qbdi_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  qbdi_pkg::qbdi_cmd_type push_data,
   input  wire                   pop,
   output qbdi_pkg::qbdi_cmd_type pop_data,
   output logic                  full,
   output logic                  empty
);
   import qbdi_pkg::*;

   qbdi_cmd_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CW-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == FIFO_CW'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = wr_ff + FIFO_AW'(1);
      end
      if (pop && !empty) begin
         rd_in = rd_ff + FIFO_AW'(1);
      end
      cnt_in = cnt_ff + FIFO_CW'(push && !full) - FIFO_CW'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/qbdi_front.sv
// ----------------------------------------------------------------------------
// qbdi_front
// Accepts samples, runs the biquad on one shared multiplier, takes the
// derivative and its square, and queues the results that each sample emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qbdi_front (
   input  wire                    clock,
   input  wire                    reset,
   input  qbdi_pkg::qbdi_coef_type coef,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire signed [12:0]      req_sample,
   input  wire                    req_first,
   input  wire                    req_last,
   output logic                   push,
   output qbdi_pkg::qbdi_cmd_type push_data,
   input  wire                    full
);
   import qbdi_pkg::*;

   localparam logic [3:0] F_IDLE = 4'd0;
   localparam logic [3:0] F_M0   = 4'd1;
   localparam logic [3:0] F_M1   = 4'd2;
   localparam logic [3:0] F_M2   = 4'd3;
   localparam logic [3:0] F_M3   = 4'd4;
   localparam logic [3:0] F_M4   = 4'd5;
   localparam logic [3:0] F_M5   = 4'd6;
   localparam logic [3:0] F_SQ   = 4'd7;
   localparam logic [3:0] F_E0   = 4'd8;
   localparam logic [3:0] F_E1   = 4'd9;
   localparam logic [3:0] F_E2   = 4'd10;

   logic [3:0]               state_ff, state_in;
   logic signed [12:0]       x_ff;
   logic                     last_ff;
   logic signed [41:0]       prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [BP_W-1:0]   y_ff;
   logic signed [DLY_W-1:0]  d1_ff, d2_ff;
   logic signed [BP_W-1:0]   hist_ff [5];
   logic [2:0]               count_ff, c_ff;
   logic                     fresh_ff;
   logic [SQ_W-1:0]          sq_ff;

   logic signed [COEF_W-1:0] mul_a;
   logic signed [BP_W-1:0]   mul_b;
   logic signed [ACC_W-1:0]  prod16, ysum, dsum;
   logic signed [26:0]       deriv;
   logic [26:0]              dabs;
   logic [53:0]              dsq;
   logic [47:0]              dsq_r;
   logic [SQ_W-1:0]          sq_sat;
   logic                     shrt;

   assign req_ready = (state_ff == F_IDLE);
   assign prod16    = {{(ACC_W-46){prod_ff[41]}}, prod_ff, 4'b0000};
   assign ysum      = prod16 + ACC_W'(d1_ff) + ACC_W'(8192);
   assign dsum      = acc_ff + ACC_W'(prod_ff);
   assign shrt      = last_ff && (c_ff < 3'd4);

   // Derivative over the freshly shifted history, then its rounded square.
   assign deriv  = 27'(hist_ff[4]) + (27'(hist_ff[3]) <<< 1)
                 - (27'(hist_ff[1]) <<< 1) - 27'(hist_ff[0]);
   assign dabs   = deriv[26] ? 27'(-deriv) : 27'(deriv);
   assign dsq    = 54'(dabs) * 54'(dabs);
   assign dsq_r  = 48'((dsq + 54'd32) >> 6);
   assign sq_sat = (dsq_r > 48'(SQ_W'('1))) ? '1 : dsq_r[SQ_W-1:0];

   always_comb begin
      mul_a = coef.b0;
      mul_b = BP_W'(x_ff);
      case (state_ff)
         F_M1:    mul_a = coef.b1;
         F_M2:    begin mul_a = coef.fb1; mul_b = y_ff; end
         F_M3:    mul_a = coef.b2;
         F_M4:    begin mul_a = coef.fb2; mul_b = y_ff; end
         default: mul_a = coef.b0;
      endcase
   end

   always_comb begin
      push      = 1'b0;
      push_data = '{clr: fresh_ff, bp: hist_ff[2], sq: sq_ff, eor: 1'b0, shrt: shrt};
      state_in  = state_ff;
      case (state_ff)
         F_IDLE: if (req_valid) state_in = F_M0;
         F_M0:   state_in = F_M1;
         F_M1:   state_in = F_M2;
         F_M2:   state_in = F_M3;
         F_M3:   state_in = F_M4;
         F_M4:   state_in = F_M5;
         F_M5:   state_in = F_SQ;
         F_SQ:   state_in = F_E0;
         F_E0: begin
            if (c_ff >= 3'd2) begin
               push = !full;
               if (!full) state_in = last_ff ? F_E1 : F_IDLE;
            end else begin
               state_in = last_ff ? F_E1 : F_IDLE;
            end
         end
         F_E1: begin
            push_data.bp = hist_ff[1];
            push_data.sq = '0;
            if (c_ff >= 3'd1) begin
               push = !full;
               if (!full) state_in = F_E2;
            end else begin
               state_in = F_E2;
            end
         end
         F_E2: begin
            push_data.bp  = hist_ff[0];
            push_data.sq  = '0;
            push_data.eor = 1'b1;
            push = !full;
            if (!full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
         fresh_ff <= 1'b1;
         d1_ff    <= '0;
         d2_ff    <= '0;
         for (int i = 0; i < 5; i++) hist_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         // The flush of a record marks the next one fresh again below.
         if (push && (state_ff != F_E2)) fresh_ff <= 1'b0;
         case (state_ff)
            F_IDLE: begin
               if (req_valid && req_first) begin
                  count_ff <= '0;
                  fresh_ff <= 1'b1;
                  d1_ff    <= '0;
                  d2_ff    <= '0;
                  for (int i = 0; i < 5; i++) hist_ff[i] <= '0;
               end
            end
            F_M3: d1_ff <= sat_dly(dsum);
            F_M5: begin
               d2_ff      <= sat_dly(dsum);
               hist_ff[0] <= y_ff;
               for (int i = 1; i < 5; i++) hist_ff[i] <= hist_ff[i-1];
               c_ff       <= count_ff;
               if (count_ff < 3'd5) count_ff <= count_ff + 3'd1;
            end
            F_E2: begin
               if (!full) begin
                  count_ff <= '0;
                  fresh_ff <= 1'b1;
                  d1_ff    <= '0;
                  d2_ff    <= '0;
                  for (int i = 0; i < 5; i++) hist_ff[i] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 42'(mul_a) * 42'(mul_b);
      if (req_valid && req_ready) begin
         x_ff    <= req_sample;
         last_ff <= req_last;
      end
      if (state_ff == F_M1) y_ff <= sat_bp(ysum >>> 14);
      if (state_ff == F_M2) acc_ff <= prod16 + ACC_W'(d2_ff);
      if (state_ff == F_M4) acc_ff <= prod16;
      if (state_ff == F_SQ) sq_ff <= (c_ff >= 3'd4) ? sq_sat : '0;
   end

endmodule
`default_nettype wire

### hw/rtl/qbdi_back.sv
// ----------------------------------------------------------------------------
// qbdi_back
// Moving-window integrator: stores each square in the ring, sums the window
// one entry a cycle, scales it and presents the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qbdi_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire [6:0]              window_len,
   input  wire [15:0]             window_gain,
   input  qbdi_pkg::qbdi_cmd_type pop_data,
   input  wire                    empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic signed [23:0]     rsp_bandpass_value,
   output logic [39:0]            rsp_integrated_value,
   output logic                   rsp_end_of_record,
   output logic                   rsp_record_too_short
);
   import qbdi_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_WR   = 3'd1;
   localparam logic [2:0] B_SUM  = 3'd2;
   localparam logic [2:0] B_MUL  = 3'd3;
   localparam logic [2:0] B_RND  = 3'd4;
   localparam logic [2:0] B_OUT  = 3'd5;

   logic [2:0]            state_ff;
   qbdi_cmd_type          cmd_ff;
   logic [SQ_W-1:0]       ring_ff [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] valid_ff, valid_in;
   logic [RING_AW-1:0]    ptr_ff, addr_ff, idx;
   logic [LEN_W-1:0]      len_ff, issued_ff, len_eff;
   logic                  pend_ff, rval_ff;
   logic [SQ_W-1:0]       rdata_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [63:0]           prod_ff;
   logic [SUM_W-1:0]      rnd;
   logic                  issue;

   assign pop   = (state_ff == B_IDLE) && !empty;
   assign idx   = cmd_ff.clr ? '0 : ptr_ff;
   assign issue = (state_ff == B_SUM) && (issued_ff != len_ff);
   assign rnd   = SUM_W'((prod_ff + 64'd32768) >> 16);

   always_comb begin
      if (window_len == 7'd0) len_eff = LEN_W'(1);
      else if (window_len > 7'(MAX_WINDOW)) len_eff = LEN_W'(MAX_WINDOW);
      else len_eff = LEN_W'(window_len);
      valid_in      = cmd_ff.clr ? '0 : valid_ff;
      valid_in[idx] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         valid_ff  <= '0;
         ptr_ff    <= '0;
         pend_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         pend_ff <= issue;
         case (state_ff)
            B_IDLE: if (!empty) state_ff <= B_WR;
            B_WR: begin
               valid_ff <= valid_in;
               ptr_ff   <= idx + RING_AW'(1);
               state_ff <= B_SUM;
            end
            B_SUM: if (!issue && !pend_ff) state_ff <= B_MUL;
            B_MUL: state_ff <= B_RND;
            B_RND: begin
               rsp_valid <= 1'b1;
               state_ff  <= B_OUT;
            end
            B_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cmd_ff <= pop_data;
      if (state_ff == B_WR) begin
         ring_ff[idx] <= cmd_ff.sq;
         addr_ff      <= idx;
         issued_ff    <= '0;
         len_ff       <= len_eff;
         sum_ff       <= '0;
      end
      if (issue) begin
         rdata_ff  <= ring_ff[addr_ff];
         rval_ff   <= valid_ff[addr_ff];
         addr_ff   <= addr_ff - RING_AW'(1);
         issued_ff <= issued_ff + LEN_W'(1);
      end
      // The window never exceeds the sum width, so no clamp is needed here.
      if (pend_ff && rval_ff) sum_ff <= sum_ff + SUM_W'(rdata_ff);
      if (state_ff == B_MUL) prod_ff <= 64'(sum_ff) * 64'(window_gain);
      if (state_ff == B_RND) begin
         rsp_bandpass_value   <= cmd_ff.bp;
         rsp_integrated_value <= (rnd > SUM_W'(SQ_W'('1))) ? '1 : rnd[SQ_W-1:0];
         rsp_end_of_record    <= cmd_ff.eor;
         rsp_record_too_short <= cmd_ff.shrt;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/qrs_bandpass_derivative_integrator.sv
// ----------------------------------------------------------------------------
// qrs_bandpass_derivative_integrator
// QRS pre-processing: biquad band-pass, five-point derivative, square and
// moving-window integration of ECG samples, one record at a time.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    sample, first, last
// rsp       out        rsp_valid/rsp_ready    bandpass, integrated, eor, short
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// The front takes a new sample only from idle, after the last one is done; the
// five biquad products share one 18x24 multiplier, one per cycle, then the SQ
// state squares the derivative and the emitted results are queued at one per
// cycle while the queue is not full.
// Each result is then popped, stored, summed over the effective window, scaled,
// rounded and offered by the integrator, whose sum reads the 64-entry square
// ring one entry per cycle through its single read port.
// Reset is synchronous and clears all record state; the ring is cleared by
// per-entry valid bits, so there is no clearing pass.
// A stalled result holds the integrator, and the four-entry queue lets the
// front keep taking samples until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qrs_bandpass_derivative_integrator (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire signed [12:0] req_sample,
   input  wire               req_first,
   input  wire               req_last,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [23:0] rsp_bandpass_value,
   output logic [39:0]       rsp_integrated_value,
   output logic              rsp_end_of_record,
   output logic              rsp_record_too_short,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [2:0]         csr_index,
   input  wire [17:0]        csr_data
);
   import qbdi_pkg::*;

   qbdi_coef_type coef_ff;
   logic [6:0]    wlen_ff;
   logic [15:0]   gain_ff;
   qbdi_cmd_type  push_data, pop_data;
   logic          push, pop, full, empty;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         wlen_ff <= 7'd37;
         gain_ff <= 16'd1771;
      end else if (csr_valid) begin
         case (csr_index)
            REG_B0:   coef_ff.b0  <= csr_data;
            REG_B1:   coef_ff.b1  <= csr_data;
            REG_B2:   coef_ff.b2  <= csr_data;
            REG_FB1:  coef_ff.fb1 <= csr_data;
            REG_FB2:  coef_ff.fb2 <= csr_data;
            REG_WLEN: wlen_ff     <= csr_data[6:0];
            REG_GAIN: gain_ff     <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   qbdi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_first  (req_first),
      .req_last   (req_last),
      .push       (push),
      .push_data  (push_data),
      .full       (full)
   );

   qbdi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   qbdi_back u_back (
      .clock                (clock),
      .reset                (reset),
      .window_len           (wlen_ff),
      .window_gain          (gain_ff),
      .pop_data             (pop_data),
      .empty                (empty),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_bandpass_value   (rsp_bandpass_value),
      .rsp_integrated_value (rsp_integrated_value),
      .rsp_end_of_record    (rsp_end_of_record),
      .rsp_record_too_short (rsp_record_too_short)
   );

   // The front never offers a transfer into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue push while full");

   // The integrator never takes a command from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue pop while empty");

   // No result is offered in the cycle after a reset cycle.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");

endmodule
`default_nettype wire

### tb/tb_qrs_bandpass_derivative_integrator.sv
// ----------------------------------------------------------------------------
// tb_qrs_bandpass_derivative_integrator
// Self-checking bench for the QRS band-pass, derivative and integrator block.
// A bit-exact predictor in a small scoreboard class computes the results of
// every accepted sample. Directed records cover the field extremes, short
// records, restarts and flushes. Random records then run under several
// coefficient and window settings, with random idling on both channels in the first four.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_qrs_bandpass_derivative_integrator;
   import qbdi_pkg::*;

   // A window change needs the integrator to finish; allow generously for it.
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT   = 5000;
   localparam int ITEMS_PER_SET = 77;

   typedef struct {
      logic signed [23:0] bandpass;
      logic [39:0]        integrated;
      logic               eor;
      logic               too_short;
   } qrs_result_type;

   // Bit-exact predictor of the datapath plus the queue of pending results.
   class qrs_scoreboard;
      logic signed [17:0] b0, b1, b2, fb1, fb2;
      logic [6:0]         wlen;
      logic [15:0]        gain;
      longint             dly1, dly2;
      longint             bp_hist[5];
      logic [63:0]        sq_ring[MAX_WINDOW];
      int                 ring_ptr;
      int                 count;
      qrs_result_type     expected_q[$];
      int                 errors;
      int                 samples;
      int                 results;
      int                 records;

      function new();
         b0 = 0; b1 = 0; b2 = 0; fb1 = 0; fb2 = 0;
         wlen = 37;
         gain = 1771;
         errors = 0; samples = 0; results = 0; records = 0;
         clear_record();
      endfunction

      function void clear_record();
         dly1 = 0;
         dly2 = 0;
         foreach (bp_hist[i]) bp_hist[i] = 0;
         foreach (sq_ring[i]) sq_ring[i] = 0;
         ring_ptr = 0;
         count = 0;
      endfunction

      function longint clamp(longint v, int w);
         longint hi;
         hi = (longint'(1) <<< (w - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      function void set_reg(logic [2:0] idx, logic [17:0] data);
         case (idx)
            REG_B0:   b0 = data;
            REG_B1:   b1 = data;
            REG_B2:   b2 = data;
            REG_FB1:  fb1 = data;
            REG_FB2:  fb2 = data;
            REG_WLEN: wlen = data[6:0];
            REG_GAIN: gain = data[15:0];
            default: ;
         endcase
      endfunction

      // Stores one square in the ring and queues the result that it yields.
      function void emit(longint bp, logic [63:0] sq, logic eor, logic shrt);
         int             len, idx;
         logic [63:0]    sum, acc;
         qrs_result_type r;
         idx = ring_ptr;
         sq_ring[idx] = sq;
         ring_ptr = (idx + 1) % MAX_WINDOW;
         len = wlen;
         if (len < 1) len = 1;
         if (len > MAX_WINDOW) len = MAX_WINDOW;
         sum = 0;
         for (int n = 0; n < len; n++) begin
            sum = sum + sq_ring[idx];
            if (sum > 64'hFFFF_FFFF_FFFF) sum = 64'hFFFF_FFFF_FFFF;
            idx = (idx == 0) ? MAX_WINDOW - 1 : idx - 1;
         end
         // The product wraps at 64 bits just as the datapath definition does.
         acc = (sum * {48'd0, gain} + 64'd32768) >> 16;
         if (acc > 64'hFF_FFFF_FFFF) acc = 64'hFF_FFFF_FFFF;
         r.bandpass = bp[23:0];
         r.integrated = acc[39:0];
         r.eor = eor;
         r.too_short = shrt;
         expected_q = {expected_q, r};
      endfunction

      function void note_sample(logic signed [12:0] sample, logic first, logic last);
         longint      x, y, b0l, b1l, b2l, f1l, f2l, d, dd;
         logic [63:0] sq;
         int          c;
         logic        shrt;
         b0l = b0; b1l = b1; b2l = b2; f1l = fb1; f2l = fb2;
         samples++;
         if (first) clear_record();
         c = count;
         x = sample;
         y = clamp((b0l * x * 16 + dly1 + 8192) >>> 14, 24);
         dly1 = clamp(b1l * x * 16 + f1l * y + dly2, 48);
         dly2 = clamp(b2l * x * 16 + f2l * y, 48);
         for (int i = 4; i > 0; i--) bp_hist[i] = bp_hist[i-1];
         bp_hist[0] = y;
         if (count < 5) count++;
         sq = 0;
         if (c >= 4) begin
            d = bp_hist[4] + 2 * bp_hist[3] - 2 * bp_hist[1] - bp_hist[0];
            dd = (d < 0) ? -d : d;
            sq = (dd * dd + 32) >> 6;
            if (sq > 64'hFF_FFFF_FFFF) sq = 64'hFF_FFFF_FFFF;
         end
         if (!last) begin
            if (c >= 2) emit(bp_hist[2], sq, 1'b0, 1'b0);
            return;
         end
         // The last sample flushes the two results still held back.
         records++;
         shrt = (c < 4);
         if (c >= 2) emit(bp_hist[2], sq, 1'b0, shrt);
         if (c >= 1) emit(bp_hist[1], 0, 1'b0, shrt);
         emit(bp_hist[0], 0, 1'b1, shrt);
         clear_record();
      endfunction

      function void check_result(logic signed [23:0] bp, logic [39:0] integ,
                                 logic eor, logic shrt);
         qrs_result_type e;
         results++;
         if (expected_q.size() == 0) begin
            $error("unexpected result: bandpass %0d integrated %0d", bp, integ);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (bp !== e.bandpass) begin
            $error("bandpass_value: expected %0d, got %0d", e.bandpass, bp);
            errors++;
         end
         if (integ !== e.integrated) begin
            $error("integrated_value: expected %0d, got %0d", e.integrated, integ);
            errors++;
         end
         if (eor !== e.eor) begin
            $error("end_of_record: expected %0b, got %0b", e.eor, eor);
            errors++;
         end
         if (shrt !== e.too_short) begin
            $error("record_too_short: expected %0b, got %0b", e.too_short, shrt);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [12:0] req_sample = '0;
   logic               req_first = 1'b0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_bandpass_value;
   logic [39:0]        rsp_integrated_value;
   logic               rsp_end_of_record;
   logic               rsp_record_too_short;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [17:0]        csr_data = '0;

   qrs_scoreboard sb = new();

   // Idle percentages of the sender and the receiver, changed per phase.
   int snd_idle = 32;
   int rcv_idle = 54;
   // When nonzero, the receiver holds rsp_ready low for this many cycles.
   int hold_left = 0;
   int quiet_cycles = 0;
   int settings_used = 0;

   qrs_bandpass_derivative_integrator DUT (.*);

   always #5 clock = ~clock;

   // Receiver: random back-pressure, plus the long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   // Monitor: every transfer on every channel goes through the scoreboard.
   // The watchdog ends the run if nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_sample, req_first, req_last);
         if (csr_valid && csr_ready) sb.set_reg(csr_index, csr_data);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_bandpass_value, rsp_integrated_value,
                            rsp_end_of_record, rsp_record_too_short);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Offers one sample and returns at the edge of its transfer. Valid stays
   // high after the transfer, so back-to-back samples never drop it.
   task automatic send_sample(logic signed [12:0] s, logic first, logic last);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_first  <= first;
      req_last   <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [17:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(logic [17:0] b0, logic [17:0] b1, logic [17:0] b2,
                                 logic [17:0] fb1, logic [17:0] fb2,
                                 logic [6:0] wlen, logic [15:0] gain);
      write_reg(REG_B0, b0);
      write_reg(REG_B1, b1);
      write_reg(REG_B2, b2);
      write_reg(REG_FB1, fb1);
      write_reg(REG_FB2, fb2);
      write_reg(REG_WLEN, {11'd0, wlen});
      write_reg(REG_GAIN, {2'd0, gain});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Stops offering samples until every expected result has come back, then
   // lets the integrator settle so that nothing is still in flight.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [12:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 5) return -13'sd1;
      if (r < 8) return 13'sd4095;
      if (r < 10) return 13'($urandom);
      return 13'($urandom_range(4095));
   endfunction

   task automatic send_record(int len, logic with_first);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(), with_first && (i == 0), i == len - 1);
   endtask

   // Random records, mostly of ordinary length with a few short ones, and
   // now and then a record cut off by a new start or begun without first.
   task automatic random_records(int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
         if ($urandom_range(9) == 0) begin
            for (int i = 0; i < 3; i++) send_sample(pick_sample(), i == 0, 1'b0);
            sent += 3;
         end
         send_record(len, $urandom_range(7) != 0);
         sent += len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: a realistic band-pass, directed records first.
      apply_settings(18'd2000, 18'd0, -18'sd2000, 18'd29000, -18'sd12000, 7'd37, 16'd1771);
      send_sample(13'sd4095, 1'b1, 1'b0);
      send_sample(-13'sd1, 1'b0, 1'b0);
      send_sample(13'sd0, 1'b0, 1'b0);
      send_sample(13'sd4095, 1'b0, 1'b0);
      send_sample(-13'sd1, 1'b0, 1'b1);
      // Short records of one to four samples.
      send_sample(13'sd4095, 1'b1, 1'b1);
      send_record(2, 1'b1);
      send_record(3, 1'b1);
      send_record(4, 1'b1);
      // A record started by the previous flush alone, without first.
      send_record(6, 1'b0);
      // A record interrupted by a new first before its last sample.
      send_sample(13'sd100, 1'b1, 1'b0);
      send_sample(13'sd2000, 1'b0, 1'b0);
      send_record(5, 1'b1);
      random_records(ITEMS_PER_SET - 30);
      drain();

      // Phase two: largest coefficients and an oversized window. The
      // receiver holds off long enough to fill the block and stall its input.
      apply_settings(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                     7'd127, 16'hFFFF);
      hold_left = 400;
      random_records(ITEMS_PER_SET);
      drain();

      snd_idle = 54;
      rcv_idle = 32;
      // Phase three: most negative coefficients, zero window acting as one.
      apply_settings(18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000,
                     7'd0, 16'hFFFF);
      random_records(ITEMS_PER_SET);
      drain();

      apply_settings(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                     18'($urandom), 7'd64, 16'd0);
      random_records(ITEMS_PER_SET);
      drain();

      snd_idle = 0;
      rcv_idle = 0;
      // Pass-through filter scaling each sample by sixteen, one-sample window.
      apply_settings(18'd16384, 18'd0, 18'd0, 18'd0, 18'd0, 7'd1, 16'hFFFF);
      random_records(ITEMS_PER_SET);
      drain();

      apply_settings(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                     18'($urandom), 7'($urandom_range(1, 64)), 16'($urandom));
      random_records(ITEMS_PER_SET);
      drain();

      $display("Covered %0d samples in %0d records, %0d results, %0d register settings.",
               sb.samples, sb.records, sb.results, settings_used);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/qbdi_pkg.sv
hw/rtl/qbdi_fifo.sv
hw/rtl/qbdi_front.sv
hw/rtl/qbdi_back.sv
hw/rtl/qrs_bandpass_derivative_integrator.sv
tb/tb_qrs_bandpass_derivative_integrator.sv
